// ===== sv/pibd_pkg.sv =====
`default_nettype none
package pibd_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] GENO_MISSING = 2'd3;

    localparam int NUM_W   = 32;
    localparam int DEN_W   = 48;
    localparam int MEAN_W  = 19;
    localparam int RATIO_W = 24;
    localparam int DIVD_W  = 64;

    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] sample_index;
        logic [1:0] genotype;
        logic       last_sample;
        logic [7:0] row_index;
        logic [7:0] col_index;
    } in_t;

    typedef struct packed {
        logic               result_kind;
        logic [RATIO_W-1:0] ratio;
        logic               ratio_valid;
        logic               snp_counted;
    } out_t;

    typedef struct packed {
        logic shift;
        logic copy;
    } cell_ctl_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

    localparam logic [2:0] ONE_DIAG [3] = '{3'd0, 3'd2, 3'd0};
    localparam logic [2:0] ONE_OFF [9] = '{3'd0, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd0};
    localparam logic [2:0] TWO_DIAG [9] = '{3'd0, 3'd4, 3'd0, 3'd4, 3'd4, 3'd4, 3'd0, 3'd4, 3'd0};
    // order: previous i, current i, previous j, current j
    localparam logic [2:0] TWO_OFF [81] = '{
        3'd0, 3'd2, 3'd4, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd2, 3'd0, 3'd4, 3'd3, 3'd2, 3'd4, 3'd4, 3'd4,
        3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd3, 3'd2, 3'd4, 3'd3, 3'd2, 3'd4, 3'd3, 3'd2,
        3'd4, 3'd4, 3'd4, 3'd2, 3'd3, 3'd4, 3'd0, 3'd2, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd4, 3'd2, 3'd0
    };

    // returns {valid, score}
    function automatic logic [3:0] pair_score(input logic two, input logic diag,
                                              input logic [1:0] pi, input logic [1:0] ci,
                                              input logic [1:0] pj, input logic [1:0] cj);
        logic       ok;
        logic [6:0] i81;
        logic [3:0] i9;
        logic [3:0] d9;
        logic [1:0] d3;
        logic [2:0] s;
        ok = (ci != GENO_MISSING) && (cj != GENO_MISSING);
        if (two) begin
            ok = ok && (pi != GENO_MISSING) && (pj != GENO_MISSING);
        end
        i81 = ok ? (7'(pi) * 7'd27 + 7'(ci) * 7'd9 + 7'(pj) * 7'd3 + 7'(cj)) : 7'd0;
        i9  = ok ? (4'(ci) * 4'd3 + 4'(cj)) : 4'd0;
        d9  = ok ? (4'(pi) * 4'd3 + 4'(ci)) : 4'd0;
        d3  = ok ? ci : 2'd0;
        if (two) begin
            s = diag ? TWO_DIAG[d9] : TWO_OFF[i81];
        end else begin
            s = diag ? ONE_DIAG[d3] : ONE_OFF[i9];
        end
        return {ok, s};
    endfunction

endpackage
`default_nettype wire

// ===== sv/pairwise_ibd_matrix_accumulator_unit.sv =====
`default_nettype none
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | s_data  (in_t)
// m_       | out       | m_valid / m_ready  | m_data  (out_t)
// cfg_     | in        | cfg_we             | cfg_index, cfg_wdata
//
// Genotype load without end mark: written into its cell. End of SNP: two passes
// over the rotating genotype cell ring, with the Q.16 mean worked out between
// them in the shared bit-serial divider.
// Matrix read: the ratio comes from the 64-step divider.
// Reset and clear: a sweep over all MAX_SAMPLES*(MAX_SAMPLES+1)/2 entries of the
// accumulator memory, one entry a cycle, with s_ready low.
// One item is worked on at a time; a result waits in the output register.
module pairwise_ibd_matrix_accumulator_unit import pibd_pkg::*; #(
    parameter int MAX_SAMPLES = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_t        s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_t            m_data,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [8:0] cfg_wdata
);

    localparam int IW    = $clog2(MAX_SAMPLES);
    localparam int NW    = $clog2(MAX_SAMPLES + 1);
    localparam int TRI   = MAX_SAMPLES * (MAX_SAMPLES + 1) / 2;
    localparam int KW    = $clog2(TRI);
    localparam int KBW   = $clog2(TRI + 1);
    localparam int PAIRS = MAX_SAMPLES * (MAX_SAMPLES - 1) / 2;
    localparam int CNTW  = $clog2(PAIRS + 1);
    localparam int SUMW  = $clog2(4 * PAIRS + 1);
    localparam int RW    = NUM_W + DEN_W;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_P1   = 4'd2;
    localparam logic [3:0] S_MST  = 4'd3;
    localparam logic [3:0] S_MW   = 4'd4;
    localparam logic [3:0] S_P2   = 4'd5;
    localparam logic [3:0] S_COPY = 4'd6;
    localparam logic [3:0] S_RDK  = 4'd7;
    localparam logic [3:0] S_RDM  = 4'd8;
    localparam logic [3:0] S_RDD  = 4'd9;
    localparam logic [3:0] S_RDIV = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic              mode_reg;
    logic [8:0]        sc_reg;
    logic              have_prev_reg;
    logic [NW-1:0]     n_c;
    logic [IW-1:0]     i_reg, t_reg;
    logic [KBW-1:0]    row_base_reg;
    logic [3:0]        gi_reg;
    logic [SUMW-1:0]   sum_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic              counted_reg;
    logic              acc_v_reg;
    logic [2:0]        score_reg;
    logic [KW-1:0]     k_reg;
    logic [KW-1:0]     clr_addr_reg;
    logic [7:0]        r_reg, c_reg;
    logic              oor_reg;
    logic [KW-1:0]     rk_reg;
    out_t              res_reg;
    out_t              m_data_reg;
    logic              m_valid_reg;

    logic [3:0]        cq [MAX_SAMPLES];
    cell_ctl_t         cell_ctl;
    logic              accept;
    logic              load_wr;
    logic [3:0]        gi, gj;
    logic              diag;
    logic              in_row;
    logic [3:0]        ps;
    logic              row_last;
    logic              pass_last;
    logic [KW-1:0]     k_c;
    logic [31:0]       rk_c;
    logic [RW-1:0]     rdata;
    logic [RW-1:0]     wdata;
    logic              we;
    logic [KW-1:0]     waddr;
    logic [KW-1:0]     raddr;
    logic [NUM_W:0]    num_sum;
    logic [DEN_W:0]    den_sum;
    logic [NUM_W-1:0]  num_new;
    logic [DEN_W-1:0]  den_new;
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DEN_W-1:0]  div_divisor;
    div_ctl_t          div_st;
    logic [DIVD_W-1:0] div_q;
    logic              p1_hit;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign load_wr = accept && (s_data.operation == OP_LOAD)
                     && (32'(s_data.sample_index) < 32'(MAX_SAMPLES));

    always_comb begin
        if (32'(sc_reg) > 32'(MAX_SAMPLES)) begin
            n_c = NW'(MAX_SAMPLES);
        end else begin
            n_c = NW'(sc_reg);
        end
    end

    assign cell_ctl.shift = (state_reg == S_P1) || (state_reg == S_P2);
    assign cell_ctl.copy  = (state_reg == S_COPY);

    // ring of genotype cells, rotating one place a cycle during a pass
    for (genvar p = 0; p < MAX_SAMPLES; p++) begin : g_cell
        pibd_cell u_cell (
            .aclk     (aclk),
            .ctl      (cell_ctl),
            .wr_en    (load_wr && (32'(s_data.sample_index) == p)),
            .wr_geno  (s_data.genotype),
            .shift_in (cq[(p + 1) % MAX_SAMPLES]),
            .q        (cq[p])
        );
    end

    assign gj        = cq[0];
    assign diag      = (t_reg == i_reg);
    assign gi        = diag ? cq[0] : gi_reg;
    assign in_row    = (t_reg >= i_reg) && (NW'(t_reg) < n_c);
    assign ps        = pair_score(mode_reg, diag, gi[3:2], gi[1:0], gj[3:2], gj[1:0]);
    assign row_last  = (t_reg == IW'(MAX_SAMPLES - 1));
    assign pass_last = row_last && (NW'(i_reg) == n_c - 1'b1);
    assign k_c       = KW'(row_base_reg + KBW'(t_reg) - KBW'(i_reg));
    assign p1_hit    = in_row && !diag && ps[3];

    assign rk_c = ((32'(r_reg) * (32'(2 * MAX_SAMPLES + 1) - 32'(r_reg))) >> 1)
                  + 32'(c_reg) - 32'(r_reg);

    // saturating accumulate on the beat read the cycle before
    assign num_sum = {1'b0, rdata[RW-1:DEN_W]} + (NUM_W + 1)'(score_reg);
    assign den_sum = {1'b0, rdata[DEN_W-1:0]} + (DEN_W + 1)'(mean_reg);
    assign num_new = num_sum[NUM_W] ? '1 : num_sum[NUM_W-1:0];
    assign den_new = den_sum[DEN_W] ? '1 : den_sum[DEN_W-1:0];

    assign we    = (state_reg == S_CLR) || acc_v_reg;
    assign waddr = (state_reg == S_CLR) ? clr_addr_reg : k_reg;
    assign wdata = (state_reg == S_CLR) ? '0 : {num_new, den_new};
    assign raddr = (state_reg == S_RDM) ? rk_reg : k_c;

    pibd_ram #(
        .WIDTH (RW),
        .DEPTH (TRI)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign div_start    = (state_reg == S_MST)
                          || ((state_reg == S_RDD) && (rdata[DEN_W-1:0] != '0));
    assign div_dividend = (state_reg == S_MST) ? (DIVD_W'(sum_reg) << 16)
                                               : {rdata[RW-1:DEN_W], 32'd0};
    assign div_divisor  = (state_reg == S_MST) ? DEN_W'(cnt_reg) : rdata[DEN_W-1:0];

    pibd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_st),
        .quotient (div_q)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLR: begin
                if (clr_addr_reg == KW'(TRI - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (s_data.operation)
                        OP_LOAD: begin
                            if (s_data.last_sample) begin
                                if ((!mode_reg || have_prev_reg) && (n_c != '0)) begin
                                    state_next = S_P1;
                                end else begin
                                    state_next = S_COPY;
                                end
                            end
                        end
                        OP_READ:  state_next = S_RDK;
                        OP_CLEAR: state_next = S_CLR;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_P1: begin
                if (pass_last) begin
                    if ((cnt_reg == '0) && !p1_hit) begin
                        state_next = S_COPY;
                    end else begin
                        state_next = S_MST;
                    end
                end
            end
            S_MST: state_next = S_MW;
            S_MW: begin
                if (div_st.done) begin
                    state_next = S_P2;
                end
            end
            S_P2: begin
                if (pass_last) begin
                    state_next = S_COPY;
                end
            end
            S_COPY: state_next = S_FIN;
            S_RDK:  state_next = oor_reg ? S_FIN : S_RDM;
            S_RDM:  state_next = S_RDD;
            S_RDD:  state_next = (rdata[DEN_W-1:0] == '0) ? S_FIN : S_RDIV;
            S_RDIV: begin
                if (div_st.done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            mode_reg      <= 1'b0;
            sc_reg        <= 9'd256;
            have_prev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            acc_v_reg     <= 1'b0;
            clr_addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index) begin
                    sc_reg <= cfg_wdata;
                end else begin
                    mode_reg <= cfg_wdata[0];
                end
            end
            if (state_reg == S_COPY) begin
                have_prev_reg <= 1'b1;
            end
            acc_v_reg <= (state_reg == S_P2) && in_row && ps[3];
            if (state_reg == S_CLR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end else begin
                clr_addr_reg <= '0;
            end
            if ((state_reg == S_FIN) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        score_reg <= ps[2:0];
        k_reg     <= k_c;
        if ((state_reg == S_IDLE) || (state_reg == S_MW)) begin
            i_reg        <= '0;
            t_reg        <= '0;
            row_base_reg <= '0;
        end else if ((state_reg == S_P1) || (state_reg == S_P2)) begin
            if (diag) begin
                gi_reg <= cq[0];
            end
            if (row_last) begin
                t_reg        <= '0;
                i_reg        <= i_reg + 1'b1;
                row_base_reg <= row_base_reg + KBW'(32'(MAX_SAMPLES) - 32'(i_reg));
            end else begin
                t_reg <= t_reg + 1'b1;
            end
        end
        if (state_reg == S_IDLE) begin
            sum_reg     <= '0;
            cnt_reg     <= '0;
            counted_reg <= 1'b0;
            r_reg       <= (s_data.row_index > s_data.col_index) ? s_data.col_index
                                                                  : s_data.row_index;
            c_reg       <= (s_data.row_index > s_data.col_index) ? s_data.row_index
                                                                  : s_data.col_index;
            oor_reg     <= (32'(s_data.row_index) >= 32'(MAX_SAMPLES))
                           || (32'(s_data.col_index) >= 32'(MAX_SAMPLES));
        end
        if ((state_reg == S_P1) && p1_hit) begin
            sum_reg <= sum_reg + SUMW'(ps[2:0]);
            cnt_reg <= cnt_reg + 1'b1;
        end
        if ((state_reg == S_MW) && div_st.done) begin
            mean_reg <= div_q[MEAN_W-1:0];
        end
        if ((state_reg == S_P2) && pass_last) begin
            counted_reg <= 1'b1;
        end
        if (state_reg == S_RDK) begin
            rk_reg <= KW'(rk_c);
        end
        case (state_reg)
            S_COPY: begin
                res_reg.result_kind <= 1'b1;
                res_reg.ratio       <= '0;
                res_reg.ratio_valid <= 1'b0;
                res_reg.snp_counted <= counted_reg;
            end
            S_RDK, S_RDD: begin
                res_reg.result_kind <= 1'b0;
                res_reg.ratio       <= '0;
                res_reg.ratio_valid <= 1'b0;
                res_reg.snp_counted <= 1'b0;
            end
            S_RDIV: begin
                if (div_st.done) begin
                    res_reg.ratio       <= (div_q > DIVD_W'(RATIO_MAX)) ? RATIO_MAX
                                                                        : div_q[RATIO_W-1:0];
                    res_reg.ratio_valid <= 1'b1;
                end
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
        if ((state_reg == S_FIN) && (!m_valid_reg || m_ready)) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_clr_no_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !acc_v_reg)
        else $error("accumulate write during clear sweep");

    a_addr_rises: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_v_reg && $past(acc_v_reg)) |-> (k_reg > $past(k_reg)))
        else $error("accumulator address not increasing within a pass");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> ((state_reg == S_MW) || (state_reg == S_RDIV)))
        else $error("divider finished outside a wait state");

    a_fin_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FIN) && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("result beat not presented");

endmodule
`default_nettype wire

// ===== sv/pibd_ram.sv =====
`default_nettype none
module pibd_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 32896
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== sv/pibd_cell.sv =====
`default_nettype none
module pibd_cell import pibd_pkg::*; (
    input  wire logic       aclk,
    input  wire cell_ctl_t  ctl,
    input  wire logic       wr_en,
    input  wire logic [1:0] wr_geno,
    input  wire logic [3:0] shift_in,
    output logic      [3:0] q
);

    // {previous, current}
    logic [3:0] q_reg;

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            q_reg <= shift_in;
        end else begin
            if (wr_en) begin
                q_reg[1:0] <= wr_geno;
            end
            if (ctl.copy) begin
                q_reg[3:2] <= q_reg[1:0];
            end
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ===== sv/pibd_div.sv =====
`default_nettype none
module pibd_div import pibd_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DEN_W-1:0]  divisor,
    output div_ctl_t               status,
    output logic      [DIVD_W-1:0] quotient
);

    localparam int CW = $clog2(DIVD_W + 1);

    logic [DEN_W-1:0]  rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DEN_W-1:0]  dsr_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              take;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign take  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], take};
        end
    end

    assign status.start = start;
    assign status.busy  = busy_reg;
    assign status.done  = done_reg;
    assign quotient     = quo_reg;

endmodule
`default_nettype wire

// ===== verif/tb_pairwise_ibd_matrix_accumulator_unit.sv =====
`default_nettype none
module tb_pairwise_ibd_matrix_accumulator_unit;
    import pibd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLES = 256;
    localparam int TRI     = SAMPLES * (SAMPLES + 1) / 2;
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_PASS = 1'b1;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_t        s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_t       m_data;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [8:0] cfg_wdata = '0;

    pairwise_ibd_matrix_accumulator_unit #(.MAX_SAMPLES(SAMPLES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // score tables, indexed [cur], [cur_i][cur_j], [prev][cur] and [prev_i][cur_i][prev_j][cur_j]
    bit [2:0] one_diag_t [3] = '{0, 2, 0};
    bit [2:0] one_off_t [3][3] = '{'{0, 1, 2}, '{1, 1, 1}, '{2, 1, 0}};
    bit [2:0] two_diag_t [3][3] = '{'{0, 4, 0}, '{4, 4, 4}, '{0, 4, 0}};
    bit [2:0] two_off_t [3][3][3][3] = '{
        '{'{'{0, 2, 4}, '{2, 3, 4}, '{4, 4, 4}},
          '{'{2, 2, 2}, '{3, 3, 3}, '{4, 4, 4}},
          '{'{4, 2, 0}, '{4, 3, 2}, '{4, 4, 4}}},
        '{'{'{2, 3, 4}, '{2, 3, 4}, '{2, 3, 4}},
          '{'{3, 3, 3}, '{3, 3, 3}, '{3, 3, 3}},
          '{'{4, 3, 2}, '{4, 3, 2}, '{4, 3, 2}}},
        '{'{'{4, 4, 4}, '{2, 3, 4}, '{0, 2, 4}},
          '{'{4, 4, 4}, '{3, 3, 3}, '{2, 2, 2}},
          '{'{4, 4, 4}, '{4, 3, 2}, '{4, 2, 0}}}
    };

    // predictor state
    bit        cur_mode;
    bit [8:0]  cur_count = 9'd256;
    bit [1:0]  geno_now [SAMPLES];
    bit [1:0]  geno_prev [SAMPLES];
    bit        have_prev;
    bit [31:0] num_acc [TRI];
    bit [47:0] den_acc [TRI];

    in_t  pending_items[$];
    out_t expected_results[$];
    int   errors, mismatches, beats_out, passes_seen, reads_seen, counted_seen;
    int   items_sent;
    bit   calm;
    bit   long_hold_done;

    function automatic int tri_pos(int i, int j);
        return i * (2 * SAMPLES - i + 1) / 2 + (j - i);
    endfunction

    // {valid, score}
    function automatic bit [3:0] ibd_score(int i, int j, bit two);
        bit [1:0] ci, cj, pi, pj;
        ci = geno_now[i];
        cj = geno_now[j];
        pi = geno_prev[i];
        pj = geno_prev[j];
        if (ci == GENO_MISSING || cj == GENO_MISSING) return 4'd0;
        if (!two) return {1'b1, (i == j) ? one_diag_t[ci] : one_off_t[ci][cj]};
        if (pi == GENO_MISSING || pj == GENO_MISSING) return 4'd0;
        return {1'b1, (i == j) ? two_diag_t[pi][ci] : two_off_t[pi][ci][pj][cj]};
    endfunction

    function automatic bit accumulate_snp(bit two);
        int n, k;
        longint unsigned total, cnt, mean, v;
        bit [3:0] sc;
        n = (cur_count > SAMPLES) ? SAMPLES : int'(cur_count);
        total = 0;
        cnt = 0;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++) begin
                sc = ibd_score(i, j, two);
                if (sc[3]) begin
                    total += sc[2:0];
                    cnt++;
                end
            end
        if (cnt == 0) return 1'b0;
        mean = (total << 16) / cnt;
        for (int i = 0; i < n; i++)
            for (int j = i; j < n; j++) begin
                sc = ibd_score(i, j, two);
                if (!sc[3]) continue;
                k = tri_pos(i, j);
                v = longint'(num_acc[k]) + sc[2:0];
                num_acc[k] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
                v = longint'(den_acc[k]) + mean;
                den_acc[k] = (v > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
            end
        return 1'b1;
    endfunction

    task automatic predict_beat(input in_t it);
        out_t r;
        int a, b, k;
        longint unsigned q;
        r = '0;
        case (it.operation)
            OP_LOAD: begin
                geno_now[it.sample_index] = it.genotype;
                if (it.last_sample) begin
                    r.result_kind = KIND_PASS;
                    if (!cur_mode) r.snp_counted = accumulate_snp(1'b0);
                    else if (have_prev) r.snp_counted = accumulate_snp(1'b1);
                    geno_prev = geno_now;
                    have_prev = 1'b1;
                    expected_results.push_back(r);
                end
            end
            OP_READ: begin
                a = it.row_index;
                b = it.col_index;
                if (a > b) begin
                    a = it.col_index;
                    b = it.row_index;
                end
                k = tri_pos(a, b);
                r.result_kind = KIND_READ;
                if (den_acc[k] != 0) begin
                    q = {num_acc[k], 32'd0} / longint'(den_acc[k]);
                    r.ratio = (q > 64'hFF_FFFF) ? RATIO_MAX : q[23:0];
                    r.ratio_valid = 1'b1;
                end
                expected_results.push_back(r);
            end
            OP_CLEAR: begin
                foreach (num_acc[x]) begin
                    num_acc[x] = '0;
                    den_acc[x] = '0;
                end
            end
            default: ;
        endcase
    endtask

    // driver
    int send_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_beat(s_data);
                items_sent++;
            end
            if (s_valid && !s_ready) begin
                // hold the beat
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_data  <= pending_items.pop_front();
                s_valid <= 1'b1;
                send_gap = calm ? 0 : $urandom_range(0, 3);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    int recv_stall;
    always @(posedge aclk) begin
        out_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (recv_stall > 0) recv_stall--;
            if (m_valid && m_ready) begin
                beats_out++;
                if (expected_results.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected result beat: %p", m_data);
                end else begin
                    e = expected_results.pop_front();
                    if (e.result_kind == KIND_PASS) passes_seen++;
                    else reads_seen++;
                    if (e.snp_counted) counted_seen++;
                    if (m_data.result_kind !== e.result_kind || m_data.ratio !== e.ratio ||
                        m_data.ratio_valid !== e.ratio_valid ||
                        m_data.snp_counted !== e.snp_counted) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display({"mismatch at %0t: kind %0d/%0d ratio %h/%h",
                                      " valid %0d/%0d counted %0d/%0d (exp/act)"},
                                     $realtime, e.result_kind, m_data.result_kind,
                                     e.ratio, m_data.ratio, e.ratio_valid,
                                     m_data.ratio_valid, e.snp_counted, m_data.snp_counted);
                    end
                end
                // stall the output for a long stretch once, mid-run
                if (beats_out == 120 && !long_hold_done) begin
                    recv_stall = 3000;
                    long_hold_done = 1'b1;
                end else begin
                    recv_stall = calm ? 0 : $urandom_range(0, 3);
                end
            end
            m_ready <= (recv_stall == 0);
        end
    end

    task automatic load_beat(input int idx, input bit [1:0] g, input bit last);
        in_t it;
        it = in_t'($urandom);
        it.operation    = OP_LOAD;
        it.sample_index = idx[7:0];
        it.genotype     = g;
        it.last_sample  = last;
        pending_items.push_back(it);
    endtask

    task automatic read_beat(input int r, input int c);
        in_t it;
        it = in_t'($urandom);
        it.operation = OP_READ;
        it.row_index = r[7:0];
        it.col_index = c[7:0];
        pending_items.push_back(it);
    endtask

    task automatic other_beat(input bit [1:0] op);
        in_t it;
        it = in_t'($urandom);
        it.operation = op;
        pending_items.push_back(it);
    endtask

    function automatic bit [1:0] rand_geno();
        return ($urandom_range(0, 4) == 0) ? GENO_MISSING : 2'($urandom_range(0, 2));
    endfunction

    task automatic snp_beats(input int n);
        for (int i = 0; i < n; i++) load_beat(i, rand_geno(), i == n - 1);
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (100) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[8:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_MODE) cur_mode = value[0];
        else cur_count = value[8:0];
    endtask

    task automatic random_phase(input bit m, input int n, input int snps);
        int lim;
        write_reg(REG_MODE, m);
        write_reg(REG_COUNT, n);
        calm = ($urandom_range(0, 3) == 0);
        lim = (n < 2) ? 2 : n;
        for (int s = 0; s < snps; s++) begin
            if ($urandom_range(0, 5) == 0)
                load_beat($urandom_range(0, 255), rand_geno(), $urandom_range(0, 1));
            snp_beats(n);
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 4) == 0)
                    read_beat($urandom_range(0, 255), $urandom_range(0, 255));
                else
                    read_beat($urandom_range(0, lim - 1), $urandom_range(0, lim - 1));
            end
            if ($urandom_range(0, 15) == 0) other_beat(OP_NONE);
        end
        drain();
    endtask

    initial begin
        #200ms;
        $display("timeout");
        $display("** pairwise_ibd_matrix_accumulator_unit: FAILED **");
        $finish;
    end

    initial begin
        int n;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        drain();

        // directed: four samples, every genotype, swapped and empty reads
        write_reg(REG_COUNT, 4);
        load_beat(0, 2'd0, 0);
        load_beat(1, 2'd1, 0);
        load_beat(2, 2'd2, 0);
        load_beat(3, GENO_MISSING, 1);
        read_beat(0, 0);
        read_beat(2, 0);
        read_beat(1, 2);
        read_beat(3, 3);
        read_beat(255, 255);
        other_beat(OP_NONE);
        load_beat(3, 2'd2, 1);
        read_beat(0, 3);
        other_beat(OP_CLEAR);
        read_beat(0, 1);
        load_beat(0, 2'd2, 1);
        read_beat(1, 0);
        drain();
        write_reg(REG_MODE, 1);
        load_beat(1, 2'd0, 1);
        read_beat(0, 1);
        read_beat(1, 1);
        drain();

        // full sample set, which also fills every genotype slot
        write_reg(REG_MODE, 0);
        write_reg(REG_COUNT, 256);
        snp_beats(256);
        read_beat(0, 255);
        read_beat(255, 128);
        read_beat(170, 85);
        read_beat(254, 254);
        drain();

        // count register beyond range and zero, one sample only
        write_reg(REG_MODE, 1);
        write_reg(REG_COUNT, 511);
        load_beat(7, rand_geno(), 1);
        read_beat(100, 200);
        drain();
        random_phase(1, 0, 2);
        random_phase(0, 1, 3);
        random_phase(1, 1, 2);

        for (int p = 0; p < 16; p++) begin
            n = ($urandom_range(0, 7) == 0) ? 24 : $urandom_range(2, 8);
            if (p == 6 || p == 12) begin
                other_beat(OP_CLEAR);
                drain();
            end
            random_phase(p[0], n, $urandom_range(5, 9));
        end

        $display("sent %0d beats; checked %0d SNP passes (%0d counted) and %0d reads",
                 items_sent, passes_seen, counted_seen, reads_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("** pairwise_ibd_matrix_accumulator_unit: PASSED **");
        end else begin
            $display("%0d failures", errors);
            $display("** pairwise_ibd_matrix_accumulator_unit: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
